### sv/kml_pkg.sv
// Shared constants, types and codes for the k-means iteration block.
// No dependencies; every other file in this block imports this package.
package kml_pkg;

  localparam int MAX_CLUSTERS = 8;
  localparam int CHANNELS     = 3;
  localparam int MAX_POINTS   = 1048576;

  localparam int CW        = 16;
  localparam int KW        = $clog2(MAX_CLUSTERS);
  localparam int SUM_W     = 36;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int ERR_W     = 54;
  localparam int DIST_W    = 34;
  localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CTR_ROW_W = CHANNELS * CW;
  localparam int ACC_ROW_W = CHANNELS * SUM_W + CNT_W;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RES_LABEL  = 2'd0,
    RES_SKIP   = 2'd1,
    RES_CENTER = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_ACTIVE = 1'b0,
    CFG_REGION = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SKIP_EMIT, ST_DIST, ST_DRAIN, ST_ACC_RD, ST_ACC_WR,
    ST_LAB_EMIT, ST_MEAN, ST_MEAN_WAIT, ST_ROW_RD, ST_ROW_LATCH,
    ST_CH_DIV, ST_CH_WAIT, ST_CTR_WR, ST_CTR_EMIT, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ERR_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ERR_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/kmeans_lloyd_iteration.sv
// One Lloyd k-means iteration. A load returns nothing. For a sample in the target region,
// one center is read from the center memory and compared per cycle, then the winning cluster's
// accumulator row is read and written back. A finish runs the shared divider once for the
// mean error and once per channel of each non-empty cluster. Memories clear through row
// valid bits, so there is no clearing pass after reset. Uses kml_pkg, kml_ram, kml_dist,
// kml_div.
module kmeans_lloyd_iteration (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  center_index,
  input  logic [7:0]  region_code,
  input  logic [15:0] value_ch0,
  input  logic [15:0] value_ch1,
  input  logic [15:0] value_ch2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [2:0]  cluster_label,
  output logic [33:0] nearest_distance,
  output logic [15:0] new_ch0,
  output logic [15:0] new_ch1,
  output logic [15:0] new_ch2,
  output logic        empty_cluster,
  output logic [33:0] mean_error,
  output logic        last_of_run
);
  import kml_pkg::*;

  state_t state, state_next;

  logic [3:0]  active_clusters;
  logic [7:0]  target_region;
  logic [KW:0] kmax;
  logic [KW-1:0] kidx;
  logic          klast;
  logic [CH_IW-1:0] ch;

  logic [CTR_ROW_W-1:0] smp_row;
  logic [DIST_W-1:0]    best;
  logic [KW-1:0]        best_lab;
  logic [ERR_W-1:0]     error_total;
  logic [CNT_W-1:0]     point_count;
  logic [DIST_W-1:0]    mean;

  logic [CHANNELS*SUM_W-1:0] fin_sums;
  logic [CNT_W-1:0]          fin_count;
  logic [CTR_ROW_W-1:0]      new_row;

  logic                 rd_v_q, rd_last_q;
  logic [KW-1:0]        rd_k_q;

  // memory ports
  logic                 ctr_wr_en, ctr_rd_en;
  logic [KW-1:0]        ctr_wr_addr;
  logic [CTR_ROW_W-1:0] ctr_wr_data, ctr_rd_data;
  logic                 acc_wr_en, acc_rd_en, acc_clear;
  logic [KW-1:0]        acc_rd_addr;
  logic [ACC_ROW_W-1:0] acc_wr_data, acc_rd_data;

  logic                 dist_valid, dist_last;
  logic [KW-1:0]        dist_k;
  logic [DIST_W-1:0]    dist_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept, slot_free, emit_skip, emit_lab, emit_ctr, accumulate, ch_last;
  logic [ERR_W:0]   err_sum;
  logic [ERR_W-1:0] err_next;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign klast     = ((KW+1)'(kidx) + (KW+1)'(1)) == kmax;
  assign ch_last   = ch == CH_IW'(CHANNELS - 1);
  assign accumulate = point_count < CNT_W'(MAX_POINTS);

  always_comb begin
    if (active_clusters == 4'd0) begin
      kmax = (KW+1)'(1);
    end else if (active_clusters > 4'(MAX_CLUSTERS)) begin
      kmax = (KW+1)'(MAX_CLUSTERS);
    end else begin
      kmax = (KW+1)'(active_clusters);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_clusters <= 4'd2;
      target_region   <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE: active_clusters <= cfg_data[3:0];
        CFG_REGION: target_region   <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(command))
            CMD_SAMPLE: state_next = (region_code == target_region) ? ST_DIST : ST_SKIP_EMIT;
            CMD_FINISH: state_next = ST_MEAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SKIP_EMIT: if (slot_free) state_next = ST_IDLE;
      ST_DIST:      if (klast) state_next = ST_DRAIN;
      ST_DRAIN:     if (dist_valid && dist_last) state_next = ST_ACC_RD;
      ST_ACC_RD:    state_next = ST_ACC_WR;
      ST_ACC_WR:    state_next = ST_LAB_EMIT;
      ST_LAB_EMIT:  if (slot_free) state_next = ST_IDLE;
      ST_MEAN:      state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_rsp.done) state_next = ST_ROW_RD;
      ST_ROW_RD:    state_next = ST_ROW_LATCH;
      ST_ROW_LATCH: begin
        if (acc_rd_data[CHANNELS*SUM_W +: CNT_W] == '0) begin
          state_next = ST_CTR_WR;
        end else begin
          state_next = ST_CH_DIV;
        end
      end
      ST_CH_DIV:    state_next = ST_CH_WAIT;
      ST_CH_WAIT:   if (div_rsp.done) state_next = ch_last ? ST_CTR_WR : ST_CH_DIV;
      ST_CTR_WR:    state_next = ST_CTR_EMIT;
      ST_CTR_EMIT:  if (slot_free) state_next = klast ? ST_CLEAR : ST_ROW_RD;
      ST_CLEAR:     state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall    = 1'b1;
    ctr_wr_en   = 1'b0;
    ctr_wr_addr = kidx;
    ctr_wr_data = new_row;
    ctr_rd_en   = 1'b0;
    acc_rd_en   = 1'b0;
    acc_rd_addr = kidx;
    acc_wr_en   = 1'b0;
    acc_clear   = 1'b0;
    emit_skip   = 1'b0;
    emit_lab    = 1'b0;
    emit_ctr    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = error_total;
    div_req.divisor  = point_count;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && cmd_t'(command) == CMD_LOAD) begin
          ctr_wr_en   = 1'b1;
          ctr_wr_addr = center_index;
          ctr_wr_data = {value_ch2, value_ch1, value_ch0};
        end
      end
      ST_SKIP_EMIT: emit_skip = slot_free;
      ST_DIST:      ctr_rd_en = 1'b1;
      ST_ACC_RD: begin
        acc_rd_en   = 1'b1;
        acc_rd_addr = best_lab;
      end
      ST_ACC_WR:    acc_wr_en = accumulate;
      ST_LAB_EMIT:  emit_lab = slot_free;
      ST_MEAN:      div_req.start = 1'b1;
      ST_ROW_RD: begin
        ctr_rd_en = 1'b1;
        acc_rd_en = 1'b1;
      end
      ST_CH_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = ERR_W'(fin_sums[ch*SUM_W +: SUM_W]);
        div_req.divisor  = fin_count;
      end
      ST_CTR_WR:    ctr_wr_en = 1'b1;
      ST_CTR_EMIT:  emit_ctr = slot_free;
      ST_CLEAR:     acc_clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // accumulator update for the winning cluster
  always_comb begin
    logic [SUM_W:0] s;
    for (int c = 0; c < CHANNELS; c++) begin
      s = {1'b0, acc_rd_data[c*SUM_W +: SUM_W]} + (SUM_W+1)'(smp_row[c*CW +: CW]);
      acc_wr_data[c*SUM_W +: SUM_W] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    end
    acc_wr_data[CHANNELS*SUM_W +: CNT_W] = acc_rd_data[CHANNELS*SUM_W +: CNT_W] + 1'b1;
  end

  assign err_sum  = {1'b0, error_total} + (ERR_W+1)'(best);
  assign err_next = err_sum[ERR_W] ? {ERR_W{1'b1}} : err_sum[ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v_q      <= 1'b0;
      error_total <= '0;
      point_count <= '0;
    end else begin
      rd_v_q <= (state == ST_DIST);
      if (state == ST_ACC_WR && accumulate) begin
        error_total <= err_next;
        point_count <= point_count + 1'b1;
      end else if (state == ST_CLEAR) begin
        error_total <= '0;
        point_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k_q    <= kidx;
    rd_last_q <= klast;
    if (accept) begin
      smp_row <= {value_ch2, value_ch1, value_ch0};
      kidx    <= '0;
    end
    if (state == ST_DIST) begin
      kidx <= kidx + 1'b1;
    end
    if (dist_valid && (dist_k == '0 || dist_val < best)) begin
      best     <= dist_val;
      best_lab <= dist_k;
    end
    if (state == ST_MEAN_WAIT && div_rsp.done) begin
      mean <= (point_count == '0) ? '0 : div_rsp.quotient[DIST_W-1:0];
    end
    if (state == ST_ROW_LATCH) begin
      fin_sums  <= acc_rd_data[CHANNELS*SUM_W-1:0];
      fin_count <= acc_rd_data[CHANNELS*SUM_W +: CNT_W];
      new_row   <= ctr_rd_data;
      ch        <= '0;
    end
    if (state == ST_CH_WAIT && div_rsp.done) begin
      new_row[ch*CW +: CW] <= div_rsp.quotient[CW-1:0];
      ch <= ch + 1'b1;
    end
    if (emit_ctr && !klast) begin
      kidx <= kidx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_skip || emit_lab || emit_ctr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit_skip || emit_lab || emit_ctr) begin
      cluster_label    <= '0;
      nearest_distance <= '0;
      new_ch0          <= '0;
      new_ch1          <= '0;
      new_ch2          <= '0;
      empty_cluster    <= 1'b0;
      mean_error       <= '0;
      last_of_run      <= 1'b1;
      if (emit_skip) begin
        result_kind <= RES_SKIP;
      end else if (emit_lab) begin
        result_kind      <= RES_LABEL;
        cluster_label    <= best_lab;
        nearest_distance <= best;
      end else begin
        result_kind   <= RES_CENTER;
        cluster_label <= kidx;
        new_ch0       <= new_row[0*CW +: CW];
        new_ch1       <= new_row[1*CW +: CW];
        new_ch2       <= new_row[2*CW +: CW];
        empty_cluster <= (fin_count == '0);
        mean_error    <= klast ? mean : '0;
        last_of_run   <= klast;
      end
    end
  end

  kml_ram #(
    .WIDTH(CTR_ROW_W),
    .DEPTH(MAX_CLUSTERS)
  ) u_center_mem (
    .clk    (clk),
    .rst    (rst),
    .clear  (1'b0),
    .wr_en  (ctr_wr_en),
    .wr_addr(ctr_wr_addr),
    .wr_data(ctr_wr_data),
    .rd_en  (ctr_rd_en),
    .rd_addr(kidx),
    .rd_data(ctr_rd_data)
  );

  kml_ram #(
    .WIDTH(ACC_ROW_W),
    .DEPTH(MAX_CLUSTERS)
  ) u_acc_mem (
    .clk    (clk),
    .rst    (rst),
    .clear  (acc_clear),
    .wr_en  (acc_wr_en),
    .wr_addr(best_lab),
    .wr_data(acc_wr_data),
    .rd_en  (acc_rd_en),
    .rd_addr(acc_rd_addr),
    .rd_data(acc_rd_data)
  );

  kml_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v_q),
    .in_last   (rd_last_q),
    .in_k      (rd_k_q),
    .center    (ctr_rd_data),
    .sample    (smp_row),
    .dist_valid(dist_valid),
    .dist_last (dist_last),
    .dist_k    (dist_k),
    .dist_val  (dist_val)
  );

  kml_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

endmodule

### sv/kml_ram.sv
// Single-port-write, registered-read memory with per-row valid bits.
// A row never written since reset or the last clear reads as zero. Uses kml_pkg.
module kml_ram #(
  parameter int WIDTH = kml_pkg::CTR_ROW_W,
  parameter int DEPTH = kml_pkg::MAX_CLUSTERS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import kml_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
    if (rst) begin
      vld_q <= 1'b0;
    end else if (rd_en) begin
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

### sv/kml_dist.sv
// Squared-distance stage: per-channel squares registered, then summed.
// Carries the center index and a last tag alongside. Uses kml_pkg.
module kml_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_last,
  input  logic [kml_pkg::KW-1:0]        in_k,
  input  logic [kml_pkg::CTR_ROW_W-1:0] center,
  input  logic [kml_pkg::CTR_ROW_W-1:0] sample,
  output logic                          dist_valid,
  output logic                          dist_last,
  output logic [kml_pkg::KW-1:0]        dist_k,
  output logic [kml_pkg::DIST_W-1:0]    dist_val
);
  import kml_pkg::*;

  localparam int SQ_W  = 2 * CW;
  localparam int ACC_W = SQ_W + $clog2(CHANNELS + 1);

  logic [SQ_W-1:0]  sq [CHANNELS];
  logic [CW-1:0]    diff [CHANNELS];
  logic [ACC_W-1:0] acc;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (sample[c*CW +: CW] >= center[c*CW +: CW]) begin
        diff[c] = sample[c*CW +: CW] - center[c*CW +: CW];
      end else begin
        diff[c] = center[c*CW +: CW] - sample[c*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      sq[c] <= SQ_W'(diff[c]) * SQ_W'(diff[c]);
    end
    dist_k    <= in_k;
    dist_last <= in_last;
    if (rst) begin
      dist_valid <= 1'b0;
    end else begin
      dist_valid <= in_valid;
    end
  end

  always_comb begin
    acc = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = acc + ACC_W'(sq[c]);
    end
    // squares are non-negative, so clamping the total matches a running clamp
    if (acc > ACC_W'({DIST_W{1'b1}})) begin
      dist_val = {DIST_W{1'b1}};
    end else begin
      dist_val = acc[DIST_W-1:0];
    end
  end

endmodule

### sv/kml_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the mean-error and center-update divisions. Uses kml_pkg.
module kml_div (
  input  logic              clk,
  input  logic              rst,
  input  kml_pkg::div_req_t req,
  output kml_pkg::div_rsp_t rsp
);
  import kml_pkg::*;

  localparam int STEP_W = $clog2(ERR_W);

  logic             busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0] rem;
  logic [ERR_W-1:0] quo;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[ERR_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      quo <= {quo[ERR_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= busy && (step == STEP_W'(ERR_W - 1));
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(ERR_W - 1)) begin
          busy <= 1'b0;
        end
        step <= step + 1'b1;
      end
    end
  end

  assign rsp.quotient = quo;

endmodule

### bench/kml_checker.sv
// Scoreboard for the k-means iteration block: tracks config and input transfers,
// keeps its own model of centers and accumulators, and checks every result transfer.
// Depends on kml_pkg.
module kml_checker
  import kml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  center_index,
  input  logic [7:0]  region_code,
  input  logic [15:0] value_ch0,
  input  logic [15:0] value_ch1,
  input  logic [15:0] value_ch2,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  result_kind,
  input  logic [2:0]  cluster_label,
  input  logic [33:0] nearest_distance,
  input  logic [15:0] new_ch0,
  input  logic [15:0] new_ch1,
  input  logic [15:0] new_ch2,
  input  logic        empty_cluster,
  input  logic [33:0] mean_error,
  input  logic        last_of_run,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  label;
    logic [33:0] near_d;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic        empty;
    logic [33:0] mean;
    logic        last;
  } km_result_t;

  localparam logic [63:0] DIST_SAT = (64'd1 << DIST_W) - 1;
  localparam logic [63:0] SUM_SAT  = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] ERR_SAT  = (64'd1 << ERR_W) - 1;

  km_result_t  expected_q[$];
  logic [15:0] centers [MAX_CLUSTERS][3];
  logic [63:0] sums    [MAX_CLUSTERS][3];
  logic [63:0] members [MAX_CLUSTERS];
  logic [63:0] err_acc;
  logic [63:0] npoints;
  logic [3:0]  k_reg;
  logic [7:0]  region_reg;

  function automatic logic [63:0] sq_dist(input logic [15:0] v[3], input int k);
    logic [63:0] d, a, b, df;
    d = 0;
    for (int c = 0; c < 3; c++) begin
      a = v[c];
      b = centers[k][c];
      df = (a >= b) ? a - b : b - a;
      d = d + df * df;
      if (d > DIST_SAT) d = DIST_SAT;
    end
    return d;
  endfunction

  task automatic model_clear();
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      members[k] = 0;
      for (int c = 0; c < 3; c++) sums[k][c] = 0;
    end
    err_acc = 0;
    npoints = 0;
  endtask

  task automatic predict_item(input logic [1:0] cmd, input logic [2:0] idx,
                              input logic [7:0] rc, input logic [15:0] v[3]);
    km_result_t  r;
    int          kmax, lab;
    logic [63:0] best, d, s, mean;
    kmax = (k_reg < 1) ? 1 : (k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : k_reg;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        for (int c = 0; c < 3; c++) centers[idx][c] = v[c];
      end
      CMD_SAMPLE: begin
        r.last = 1'b1;
        if (rc != region_reg) begin
          r.kind = RES_SKIP;
        end else begin
          lab = 0;
          best = sq_dist(v, 0);
          for (int k = 1; k < kmax; k++) begin
            d = sq_dist(v, k);
            if (d < best) begin
              best = d;
              lab = k;
            end
          end
          r.kind = RES_LABEL;
          r.label = 3'(lab);
          r.near_d = best[33:0];
          if (npoints < MAX_POINTS) begin
            npoints++;
            members[lab]++;
            for (int c = 0; c < 3; c++) begin
              s = sums[lab][c] + v[c];
              sums[lab][c] = (s > SUM_SAT) ? SUM_SAT : s;
            end
            err_acc = err_acc + best;
            if (err_acc > ERR_SAT) err_acc = ERR_SAT;
          end
        end
        expected_q.push_back(r);
      end
      CMD_FINISH: begin
        mean = (npoints != 0) ? err_acc / npoints : 0;
        for (int k = 0; k < kmax; k++) begin
          r = '0;
          if (members[k] != 0)
            for (int c = 0; c < 3; c++) centers[k][c] = 16'(sums[k][c] / members[k]);
          r.kind  = RES_CENTER;
          r.label = 3'(k);
          r.c0    = centers[k][0];
          r.c1    = centers[k][1];
          r.c2    = centers[k][2];
          r.empty = (members[k] == 0);
          r.last  = (k + 1 == kmax);
          r.mean  = r.last ? mean[33:0] : '0;
          expected_q.push_back(r);
        end
        model_clear();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    km_result_t  e;
    logic [15:0] v[3];
    if (rst) begin
      for (int k = 0; k < MAX_CLUSTERS; k++)
        for (int c = 0; c < 3; c++) centers[k][c] = 0;
      model_clear();
      k_reg = 4'd2;
      region_reg = 8'd1;
      expected_q.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, kind %0d", $time, result_kind);
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("result_kind", 64'(e.kind), 64'(result_kind));
          check_field("cluster_label", 64'(e.label), 64'(cluster_label));
          check_field("nearest_distance", 64'(e.near_d), 64'(nearest_distance));
          check_field("new_ch0", 64'(e.c0), 64'(new_ch0));
          check_field("new_ch1", 64'(e.c1), 64'(new_ch1));
          check_field("new_ch2", 64'(e.c2), 64'(new_ch2));
          check_field("empty_cluster", 64'(e.empty), 64'(empty_cluster));
          check_field("mean_error", 64'(e.mean), 64'(mean_error));
          check_field("last_of_run", 64'(e.last), 64'(last_of_run));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ACTIVE) k_reg = cfg_data[3:0];
        else region_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        v[0] = value_ch0;
        v[1] = value_ch1;
        v[2] = value_ch2;
        predict_item(command, center_index, region_code, v);
      end
    end
    pending = expected_q.size();
  end

endmodule

### bench/tb.sv
// Top of the k-means iteration bench: clock, reset, stimulus with bursty input and
// random output stalls, config phases and the verdict. Depends on kml_pkg,
// kml_checker and the kmeans_lloyd_iteration block.
module tb;
  import kml_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_GOAL   = 220;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [2:0]  center_index = '0;
  logic [7:0]  region_code = '0;
  logic [15:0] value_ch0 = '0, value_ch1 = '0, value_ch2 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [2:0]  cluster_label;
  logic [33:0] nearest_distance, mean_error;
  logic [15:0] new_ch0, new_ch1, new_ch2;
  logic        empty_cluster, last_of_run;
  int          errors, pending;
  int          cycles = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kmeans_lloyd_iteration dut (.*);

  kml_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: stall modes that change now and then, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  task automatic send(input cmd_t c, input logic [2:0] ix, input logic [7:0] rc,
                      input logic [15:0] a, input logic [15:0] b, input logic [15:0] d);
    @(negedge clk);
    in_valid <= 1'b1;
    command <= c;
    center_index <= ix;
    region_code <= rc;
    value_ch0 <= a;
    value_ch1 <= b;
    value_ch2 <= d;
    do @(posedge clk); while (in_stall);
    if (c != CMD_NONE) sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  task automatic idle_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t ix, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0]  kset;
    logic [7:0]  reg_sel;
    logic [15:0] base[3];
    int          n, kuse, phase;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: defaults are two clusters, region 1
    send(CMD_FINISH, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send(CMD_LOAD, 3'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send(CMD_LOAD, 3'd1, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_SAMPLE, 3'd0, 8'd1, 16'h0000, 16'h0000, 16'h0000);
    send(CMD_SAMPLE, 3'd7, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_SAMPLE, 3'd0, 8'd1, 16'hFFFF, 16'h0000, 16'hFFFF);
    send(CMD_LOAD, 3'd1, 8'd0, 16'd2, 16'd2, 16'd2);
    send(CMD_SAMPLE, 3'd0, 8'd1, 16'd1, 16'd1, 16'd1);   // tie goes to cluster 0
    send(CMD_SAMPLE, 3'd0, 8'd0, 16'd5, 16'd5, 16'd5);   // out of region
    send(CMD_SAMPLE, 3'd0, 8'hFF, 16'd5, 16'd5, 16'd5);
    send(CMD_NONE, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_LOAD, 3'd7, 8'hFF, 16'hAAAA, 16'h5555, 16'hFFFF);
    send(CMD_FINISH, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    idle_wait();
    write_reg(CFG_ACTIVE, 8'd8);
    write_reg(CFG_REGION, 8'd0);
    for (int k = 0; k < 8; k++)
      send(CMD_LOAD, 3'(k), 8'd0, 16'(k * 8000), 16'(k * 8000), 16'(65535 - k * 8000));
    send(CMD_SAMPLE, 3'd0, 8'd0, 16'd64000, 16'd64000, 16'd0);
    send(CMD_SAMPLE, 3'd0, 8'd0, 16'd100, 16'd100, 16'd65000);
    send(CMD_FINISH, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0);

    phase = 0;
    while (sent < ITEM_GOAL) begin
      idle_wait();
      case (phase % 6)
        0: kset = 4'd1;
        1: kset = 4'd8;
        2: kset = 4'd0;
        3: kset = 4'd15;
        default: kset = 4'($urandom_range(1, 8));
      endcase
      reg_sel = (phase % 3 == 0) ? 8'hFF : (phase % 3 == 1) ? 8'h00 : 8'($urandom);
      write_reg(CFG_ACTIVE, {4'($urandom), kset});
      write_reg(CFG_REGION, reg_sel);
      kuse = (kset == 0) ? 1 : (kset > 8) ? 8 : kset;
      for (int k = 0; k < 8; k++)
        if (k < kuse || $urandom_range(0, 3) == 0)
          send(CMD_LOAD, 3'(k), 8'($urandom), rnd_val(), rnd_val(), rnd_val());
      if (phase == 1) hold_req++;
      n = $urandom_range(4, 20);
      for (int i = 0; i < n; i++) begin
        base[0] = rnd_val();
        base[1] = rnd_val();
        base[2] = rnd_val();
        case ($urandom_range(0, 19))
          0: send(CMD_NONE, 3'($urandom), 8'($urandom), base[0], base[1], base[2]);
          1: send(CMD_LOAD, 3'($urandom), 8'($urandom), base[0], base[1], base[2]);
          2, 3: send(CMD_SAMPLE, 3'($urandom), 8'($urandom), base[0], base[1], base[2]);
          default: send(CMD_SAMPLE, 3'($urandom), reg_sel, base[0], base[1], base[2]);
        endcase
      end
      send(CMD_FINISH, 3'($urandom), 8'($urandom), rnd_val(), rnd_val(), rnd_val());
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
sv/kml_pkg.sv
sv/kml_ram.sv
sv/kml_dist.sv
sv/kml_div.sv
sv/kmeans_lloyd_iteration.sv
bench/kml_checker.sv
bench/tb.sv
